// ===== hw/rtl/token_budget_chunk_assigner_macros.svh =====
// assertion macros shared by the chunk assigner rtl
`ifndef TOKEN_BUDGET_CHUNK_ASSIGNER_MACROS_SVH
`define TOKEN_BUDGET_CHUNK_ASSIGNER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TBCA_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tbca check failed");

// next-cycle implication, checked outside reset
`define TBCA_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tbca check failed");

`endif

// ===== hw/rtl/tbca_pkg.sv =====
// shared types and constants of the chunk assigner
package tbca_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_UNIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ON   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd3;

  localparam logic POLICY_GREEDY = 1'b0;
  localparam logic POLICY_FORCED = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_CAP   = 9'b000000100,
    S_LIM   = 9'b000001000,
    S_ALGN  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_UPD   = 9'b001000000,
    S_FORCE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/tbca_if.sv =====
// handshake interfaces of the chunk assigner: request, result and config words
interface tbca_in_if #(parameter int TOKEN_BITS = 20);
  logic                  valid;
  logic                  ready;
  logic                  batch_start;
  logic                  budget_on;
  logic [TOKEN_BITS-1:0] batch_budget;
  logic [TOKEN_BITS-1:0] remaining_len;
  logic [TOKEN_BITS-1:0] reusable_est;
  logic                  first_chunk;

  modport source (output valid, batch_start, budget_on, batch_budget, remaining_len,
                  reusable_est, first_chunk, input ready);
  modport sink (input valid, batch_start, budget_on, batch_budget, remaining_len,
                reusable_est, first_chunk, output ready);
endinterface

interface tbca_out_if #(parameter int TOKEN_BITS = 20);
  logic                  valid;
  logic                  ready;
  logic [TOKEN_BITS-1:0] grant_len;
  logic                  config_error;

  modport source (output valid, grant_len, config_error, input ready);
  modport sink (input valid, grant_len, config_error, output ready);
endinterface

interface tbca_cfg_if #(parameter int TOKEN_BITS = 20);
  logic                             valid;
  logic                             ready;
  logic [tbca_pkg::CFG_IDX_W-1:0]   index;
  logic [TOKEN_BITS-1:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tbca_rem_div.sv =====
// restoring remainder unit, one quotient bit per cycle
module tbca_rem_div #(
  parameter int W = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W-1:0]        dividend,
  input  logic [W-1:0]        divisor,
  output logic [W-1:0]        remainder,
  output tbca_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     dvd_r;
  logic [W-1:0]     rem_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       trial;
  logic [W:0]       diff;

  assign trial = {rem_r, dvd_r[W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor, so W bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      rem_r <= diff[W] ? trial[W-1:0] : diff[W-1:0];
    end
  end

  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== hw/rtl/token_budget_chunk_assigner.sv =====
// top level: token-budget chunk assigner
// greedy requests pass the prep, cap, limit and align states, the remainder unit when a
// trimmed chunk needs aligning, then update and done; forced requests pass force and done
// one request in flight: a new one is taken only back in idle, after the result register
// has taken the previous result
// rst_n is synchronous: config returns to greedy, unit 64, no limit; no budget is active
`include "token_budget_chunk_assigner_macros.svh"

module token_budget_chunk_assigner #(
  parameter int TOKEN_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  tbca_in_if.sink     in_bus,
  tbca_out_if.source  out_bus,
  tbca_cfg_if.sink    cfg_bus
);

  localparam int TB = TOKEN_BITS;

  // config registers
  logic          policy_r;
  logic [TB-1:0] unit_r;
  logic          lim_on_r;
  logic [TB-1:0] max_len_r;

  // batch state
  logic [TB-1:0] budget_left_r;
  logic [TB:0]   tokens_used_r;
  logic          budget_active_r;
  logic [TB-1:0] budget_total_r;

  // per-request working registers
  logic [TB-1:0] rem_r;
  logic [TB-1:0] est_r;
  logic          first_r;
  logic [TB-1:0] reus_r;
  logic [TB-1:0] cost_r;
  logic [TB-1:0] act_r;
  logic [TB-1:0] chunk_r;
  logic          err_r;

  // result register
  logic          out_valid_r;
  logic [TB-1:0] out_chunk_r;
  logic          out_err_r;

  tbca_pkg::state_t    state_r, state_nxt;
  tbca_pkg::div_stat_t div_stat;
  logic [TB-1:0]       div_rem;
  logic                div_start;

  logic          in_acc;
  logic          out_free;
  logic [TB-1:0] min_est;
  logic [TB-1:0] cost_c;
  logic [TB-1:0] comp_c;
  logic [TB:0]   cap_c;
  logic [TB-1:0] lim_act;
  logic [TB-1:0] mc_c;
  logic          frc_err;
  logic [TB-1:0] frc_c;
  logic          frc_over;
  logic [TB-1:0] charge_n;
  logic [TB+1:0] charge_sum;
  logic [TB:0]   charge_sat;

  assign in_acc      = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == tbca_pkg::S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign out_free    = !out_valid_r || out_bus.ready;

  // greedy arithmetic, one small step per state
  assign min_est = (est_r < rem_r) ? est_r : rem_r;
  assign cost_c  = rem_r - reus_r;
  assign comp_c  = (act_r > reus_r) ? (act_r - reus_r) : '0;
  assign cap_c   = {1'b0, reus_r} + {1'b0, max_len_r};
  assign lim_act = (cap_c < {1'b0, rem_r}) ? cap_c[TB-1:0] : rem_r;
  assign mc_c    = (act_r < cost_r) ? act_r : cost_r;

  // forced-chunk arithmetic
  assign frc_err  = lim_on_r && (max_len_r < unit_r);
  assign frc_c    = (rem_r < unit_r) ? rem_r : unit_r;
  assign frc_over = budget_active_r &&
                    (({1'b0, tokens_used_r} + {2'b0, frc_c}) > {2'b0, budget_total_r});

  // saturating usage counter, shared by both policies
  assign charge_n   = (state_r == tbca_pkg::S_FORCE) ? frc_c : mc_c;
  assign charge_sum = {1'b0, tokens_used_r} + {2'b0, charge_n};
  assign charge_sat = charge_sum[TB+1] ? {(TB+1){1'b1}} : charge_sum[TB:0];

  assign div_start = (state_r == tbca_pkg::S_ALGN) && (act_r != rem_r) && (unit_r != '0);

  tbca_rem_div #(.W(TB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (act_r),
    .divisor   (unit_r),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbca_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (policy_r == tbca_pkg::POLICY_FORCED) ? tbca_pkg::S_FORCE
                                                            : tbca_pkg::S_PREP;
        end
      end
      tbca_pkg::S_PREP:  state_nxt = tbca_pkg::S_CAP;
      tbca_pkg::S_CAP:   state_nxt = tbca_pkg::S_LIM;
      tbca_pkg::S_LIM:   state_nxt = tbca_pkg::S_ALGN;
      tbca_pkg::S_ALGN:  state_nxt = div_start ? tbca_pkg::S_DIV : tbca_pkg::S_UPD;
      tbca_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_nxt = tbca_pkg::S_UPD;
        end
      end
      tbca_pkg::S_UPD:   state_nxt = tbca_pkg::S_DONE;
      tbca_pkg::S_FORCE: state_nxt = tbca_pkg::S_DONE;
      tbca_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = tbca_pkg::S_IDLE;
        end
      end
      default:           state_nxt = tbca_pkg::S_IDLE;
    endcase
  end

  // control state: config, batch state, sequencer and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= tbca_pkg::S_IDLE;
      policy_r        <= tbca_pkg::POLICY_GREEDY;
      unit_r          <= TB'(64);
      lim_on_r        <= 1'b0;
      max_len_r       <= '0;
      budget_left_r   <= '0;
      tokens_used_r   <= '0;
      budget_active_r <= 1'b0;
      budget_total_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          tbca_pkg::CFG_POLICY:     policy_r  <= cfg_bus.data[0];
          tbca_pkg::CFG_CHUNK_UNIT: unit_r    <= cfg_bus.data;
          tbca_pkg::CFG_LIMIT_ON:   lim_on_r  <= cfg_bus.data[0];
          tbca_pkg::CFG_MAX_LEN:    max_len_r <= cfg_bus.data;
          default: ;
        endcase
      end

      // batch start loads the budget before the request is worked on
      if (in_acc && in_bus.batch_start) begin
        budget_active_r <= in_bus.budget_on;
        budget_total_r  <= in_bus.batch_budget;
        budget_left_r   <= in_bus.batch_budget;
        tokens_used_r   <= '0;
      end

      if (state_r == tbca_pkg::S_UPD && budget_active_r) begin
        budget_left_r <= (mc_c > budget_left_r) ? '0 : (budget_left_r - mc_c);
        tokens_used_r <= charge_sat;
      end

      if (state_r == tbca_pkg::S_FORCE && !frc_err && !frc_over) begin
        tokens_used_r <= charge_sat;
      end

      if (state_r == tbca_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      tbca_pkg::S_IDLE: begin
        if (in_acc) begin
          rem_r   <= in_bus.remaining_len;
          est_r   <= in_bus.reusable_est;
          first_r <= in_bus.first_chunk;
        end
      end
      tbca_pkg::S_PREP: begin
        reus_r <= first_r ? min_est : '0;
      end
      tbca_pkg::S_CAP: begin
        // cached prefix is free; cap by the budget left
        cost_r <= cost_c;
        act_r  <= (budget_active_r && (cost_c > budget_left_r)) ? budget_left_r : rem_r;
      end
      tbca_pkg::S_LIM: begin
        if (lim_on_r && (comp_c > max_len_r)) begin
          act_r <= lim_act;
        end
      end
      tbca_pkg::S_DIV: begin
        // align a trimmed chunk down to the unit
        if (div_stat.done) begin
          act_r <= act_r - div_rem;
        end
      end
      tbca_pkg::S_UPD: begin
        chunk_r <= act_r;
        err_r   <= 1'b0;
      end
      tbca_pkg::S_FORCE: begin
        chunk_r <= (frc_err || frc_over) ? '0 : frc_c;
        err_r   <= frc_err;
      end
      tbca_pkg::S_DONE: begin
        if (out_free) begin
          out_chunk_r <= chunk_r;
          out_err_r   <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.grant_len    = out_chunk_r;
  assign out_bus.config_error = out_err_r;

  // checks
  `TBCA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_acc, state_r != tbca_pkg::S_IDLE)
  `TBCA_ASSERT_NOW(a_div_in_div, clk, rst_n, div_stat.busy, state_r == tbca_pkg::S_DIV)
  `TBCA_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid_r && out_err_r, out_chunk_r == '0)

endmodule

// ===== test/token_budget_chunk_assigner_test.sv =====
// self-checking testbench of the token-budget chunk assigner: directed and random requests
module token_budget_chunk_assigner_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOKEN_BITS = 20;
  localparam logic [TOKEN_BITS-1:0] TOK_MAX = '1;
  localparam logic [TOKEN_BITS:0]   USED_MAX = '1;
  localparam int NUM_SETTINGS = 8;
  localparam int REQS_PER_SETTING = 80;
  // settle time after the last drain, with margin over the longest greedy path
  localparam int SETTLE_CYCLES = 40;

  // one request word and one grant word as seen on the channels
  typedef struct packed {
    logic                  batch_start;
    logic                  budget_on;
    logic [TOKEN_BITS-1:0] batch_budget;
    logic [TOKEN_BITS-1:0] remaining_len;
    logic [TOKEN_BITS-1:0] reusable_est;
    logic                  first_chunk;
  } request_t;

  typedef struct packed {
    logic [TOKEN_BITS-1:0] grant_len;
    logic                  config_error;
  } grant_t;

  // one register setting of a random section, plus whether both sides may idle
  typedef struct {
    logic                  pol;
    logic [TOKEN_BITS-1:0] unit;
    logic                  lim;
    logic [TOKEN_BITS-1:0] max_len;
    bit                    gaps;
  } setting_t;

  logic clk;
  logic rst_n;

  tbca_in_if  #(.TOKEN_BITS(TOKEN_BITS)) in_bus ();
  tbca_out_if #(.TOKEN_BITS(TOKEN_BITS)) out_bus ();
  tbca_cfg_if #(.TOKEN_BITS(TOKEN_BITS)) cfg_bus ();

  token_budget_chunk_assigner #(.TOKEN_BITS(TOKEN_BITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // shadow copy of the register file, tracks what the block was told
  logic                  sh_policy = tbca_pkg::POLICY_GREEDY;
  logic [TOKEN_BITS-1:0] sh_unit = TOKEN_BITS'(64);
  logic                  sh_limit_on = 1'b0;
  logic [TOKEN_BITS-1:0] sh_max_len = '0;

  // shadow batch state, all zero out of reset
  logic [TOKEN_BITS-1:0] budget_left = '0;
  logic [TOKEN_BITS:0]   tokens_used = '0;
  logic                  budget_active = 1'b0;
  logic [TOKEN_BITS-1:0] budget_total = '0;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_grants = 0;
  int  n_fail = 0;
  int  n_cfg_err = 0;
  int  n_starved = 0;
  int  n_trimmed = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  bit  gaps_on = 1'b1;
  bit  rx_hold = 1'b0;

  // usage counter saturates at all ones
  function automatic void charge_tokens(logic [TOKEN_BITS-1:0] n);
    logic [TOKEN_BITS+1:0] sum;
    sum = {1'b0, tokens_used} + {2'b0, n};
    tokens_used = (sum > {1'b0, USED_MAX}) ? USED_MAX : sum[TOKEN_BITS:0];
  endfunction

  // works out the grant of one request and advances the shadow batch state
  function automatic grant_t assign_chunk(request_t r);
    logic [TOKEN_BITS-1:0] reus;
    logic [TOKEN_BITS-1:0] cost;
    logic [TOKEN_BITS-1:0] act;
    logic [TOKEN_BITS-1:0] comp;
    logic [TOKEN_BITS-1:0] mc;
    logic [TOKEN_BITS-1:0] c;
    logic [TOKEN_BITS:0]   cap;
    logic [TOKEN_BITS+1:0] sum;
    grant_t g;
    g = '0;
    // a batch start loads the budget before the request itself is handled
    if (r.batch_start) begin
      budget_active = r.budget_on;
      budget_total = r.batch_budget;
      budget_left = r.batch_budget;
      tokens_used = '0;
    end
    if (sh_policy == tbca_pkg::POLICY_GREEDY) begin
      // cached prefix is free, but only on the first chunk of a request
      reus = r.first_chunk ?
             ((r.reusable_est < r.remaining_len) ? r.reusable_est : r.remaining_len) : '0;
      cost = r.remaining_len - reus;
      act = r.remaining_len;
      if (budget_active && cost > budget_left) act = budget_left;
      if (sh_limit_on) begin
        comp = (act > reus) ? act - reus : '0;
        if (comp > sh_max_len) begin
          cap = {1'b0, reus} + {1'b0, sh_max_len};
          act = (cap < {1'b0, r.remaining_len}) ? cap[TOKEN_BITS-1:0] : r.remaining_len;
        end
      end
      // only a trimmed chunk is aligned down
      if (act != r.remaining_len && sh_unit != '0) act = (act / sh_unit) * sh_unit;
      g.grant_len = act;
      if (budget_active) begin
        mc = (act < cost) ? act : cost;
        budget_left = (mc > budget_left) ? '0 : budget_left - mc;
        charge_tokens(mc);
      end
    end else if (sh_limit_on && sh_max_len < sh_unit) begin
      // forced chunk cannot fit under the length limit: flag it, leave state alone
      g.config_error = 1'b1;
    end else begin
      c = (r.remaining_len < sh_unit) ? r.remaining_len : sh_unit;
      sum = {1'b0, tokens_used} + {2'b0, c};
      if (!(budget_active && sum > {2'b0, budget_total})) begin
        g.grant_len = c;
        charge_tokens(c);
      end
    end
    return g;
  endfunction

  // token count: mostly within lim, sometimes a full-width pattern or an extreme
  function automatic logic [TOKEN_BITS-1:0] pick_tokens(int unsigned lim);
    logic [TOKEN_BITS-1:0] v;
    case ($urandom_range(0, 11))
      0: v = TOKEN_BITS'($urandom());
      1: v = $urandom_range(0, 1) ? TOK_MAX : '0;
      default: v = TOKEN_BITS'($urandom_range(0, lim));
    endcase
    return v;
  endfunction

  task automatic add_req(input logic bs, input logic bon, input logic [TOKEN_BITS-1:0] bud,
                         input logic [TOKEN_BITS-1:0] rem, input logic [TOKEN_BITS-1:0] est,
                         input logic first);
    request_t r;
    r.batch_start = bs;
    r.budget_on = bon;
    r.batch_budget = bud;
    r.remaining_len = rem;
    r.reusable_est = est;
    r.first_chunk = first;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  // register write over the config channel, shadow updated at the accepting edge
  task automatic write_reg(input logic [tbca_pkg::CFG_IDX_W-1:0] idx,
                           input logic [TOKEN_BITS-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      tbca_pkg::CFG_POLICY:     sh_policy = val[0];
      tbca_pkg::CFG_CHUNK_UNIT: sh_unit = val;
      tbca_pkg::CFG_LIMIT_ON:   sh_limit_on = val[0];
      tbca_pkg::CFG_MAX_LEN:    sh_max_len = val;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  // block is idle once every queued request is taken and every grant is back
  task automatic drain();
    while (n_accepted != n_queued || expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver: presents the next pending word, holds it until taken,
  // and idles in random bursts when allowed
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.batch_start <= 1'b0;
      in_bus.budget_on <= 1'b0;
      in_bus.batch_budget <= '0;
      in_bus.remaining_len <= '0;
      in_bus.reusable_est <= '0;
      in_bus.first_chunk <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_grants.push_back(assign_chunk({in_bus.batch_start, in_bus.budget_on,
                                                in_bus.batch_budget, in_bus.remaining_len,
                                                in_bus.reusable_est, in_bus.first_chunk}));
        n_accepted++;
      end
      // a word still waiting for ready stays where it is
      if (!in_bus.valid || in_bus.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(0, 15);
          in_bus.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.batch_start <= r.batch_start;
          in_bus.budget_on <= r.budget_on;
          in_bus.batch_budget <= r.batch_budget;
          in_bus.remaining_len <= r.remaining_len;
          in_bus.reusable_est <= r.reusable_est;
          in_bus.first_chunk <= r.first_chunk;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // grant monitor: checks each taken word against the oldest expectation,
  // stalls in random bursts and during the long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_grants.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected grant word, expected none, actual grant_len=%0d config_error=%0b",
                   $time, out_bus.grant_len, out_bus.config_error);
        end else begin
          grant_t g;
          g = expected_grants.pop_front();
          n_grants++;
          if (g.config_error) n_cfg_err++;
          else if (g.grant_len == 0) n_starved++;
          if (out_bus.grant_len !== g.grant_len) begin
            n_fail++;
            $display("%0t: grant_len mismatch, expected %0d actual %0d",
                     $time, g.grant_len, out_bus.grant_len);
          end
          if (out_bus.config_error !== g.config_error) begin
            n_fail++;
            $display("%0t: config_error mismatch, expected %0b actual %0b",
                     $time, g.config_error, out_bus.config_error);
          end
        end
      end
      if (rx_hold) begin
        out_bus.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 15);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // back-pressure: the receiver holds off for a long stretch while requests keep
  // coming, so the block sits on a finished grant and stops taking input
  initial begin
    wait (n_accepted >= 40);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // run limit, well above the slowest legal run
  initial begin
    #(4_000_000);
    $display("[token_budget_chunk_assigner] ERROR");
    $finish;
  end

  // main sequence: reset, directed requests, random sections over several settings
  initial begin
    setting_t plan[NUM_SETTINGS];
    int unsigned scale;
    int n;
    int batch_len;
    plan[0] = '{tbca_pkg::POLICY_GREEDY, 20'd64,  1'b1, 20'd100, 1'b1};
    plan[1] = '{tbca_pkg::POLICY_GREEDY, 20'd1,   1'b0, 20'd0,   1'b1};
    plan[2] = '{tbca_pkg::POLICY_GREEDY, 20'd16,  1'b1, 20'd0,   1'b1};
    plan[3] = '{tbca_pkg::POLICY_FORCED, 20'd100, 1'b0, TOK_MAX, 1'b1};
    plan[4] = '{tbca_pkg::POLICY_GREEDY, TOK_MAX, 1'b1, TOK_MAX, 1'b0};
    plan[5] = '{tbca_pkg::POLICY_FORCED, 20'd7,   1'b1, 20'd3,   1'b1};
    plan[6] = '{tbca_pkg::POLICY_FORCED, 20'd32,  1'b1, 20'd40,  1'b1};
    plan[7] = '{tbca_pkg::POLICY_GREEDY, 20'd48,  1'b1, 20'd200, 1'b0};

    // config channel known from time zero
    cfg_bus.valid = 1'b0;
    cfg_bus.index = tbca_pkg::CFG_POLICY;
    cfg_bus.data = '0;

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // greedy, unit 64, at most 100 compute tokens per chunk
    write_reg(tbca_pkg::CFG_POLICY, TOKEN_BITS'(tbca_pkg::POLICY_GREEDY));
    write_reg(tbca_pkg::CFG_CHUNK_UNIT, 20'd64);
    write_reg(tbca_pkg::CFG_LIMIT_ON, 20'd1);
    write_reg(tbca_pkg::CFG_MAX_LEN, 20'd100);
    add_req(1'b0, 1'b1, TOK_MAX, 20'd500, 20'd50, 1'b1);    // before any batch start
    add_req(1'b1, 1'b1, 20'd200, 20'd1000, 20'd300, 1'b1);  // budget trims
    add_req(1'b0, 1'b0, 20'd0, 20'd1000, 20'd300, 1'b0);    // no reuse discount
    add_req(1'b0, 1'b1, 20'd0, 20'd0, 20'd0, 1'b1);         // nothing left to do
    add_req(1'b1, 1'b0, TOK_MAX, TOK_MAX, TOK_MAX, 1'b1);   // no budget, all ones
    add_req(1'b1, 1'b1, TOK_MAX, TOK_MAX, 20'd0, 1'b0);
    add_req(1'b0, 1'b0, 20'd0, 20'd70, 20'd100, 1'b1);      // prefix longer than request
    add_req(1'b1, 1'b1, 20'd0, 20'd300, 20'd20, 1'b1);      // empty budget
    add_req(1'b1, 1'b1, 20'd5000, 20'd64, 20'd0, 1'b1);     // fits untrimmed
    drain();

    // forced chunks of 64 under the same limit
    write_reg(tbca_pkg::CFG_POLICY, TOKEN_BITS'(tbca_pkg::POLICY_FORCED));
    add_req(1'b1, 1'b1, 20'd100, 20'd10, 20'd0, 1'b0);
    add_req(1'b0, 1'b0, 20'd0, 20'd64, 20'd5, 1'b1);
    add_req(1'b0, 1'b0, 20'd0, 20'd1000, 20'd0, 1'b0);      // would overrun the budget
    add_req(1'b1, 1'b0, 20'd0, TOK_MAX, TOK_MAX, 1'b1);
    add_req(1'b1, 1'b1, 20'd0, 20'd0, 20'd0, 1'b0);
    drain();

    // limit below the unit: forced mode reports a configuration error
    write_reg(tbca_pkg::CFG_MAX_LEN, 20'd10);
    add_req(1'b1, 1'b1, 20'd100, 20'd500, 20'd0, 1'b1);
    add_req(1'b0, 1'b0, 20'd0, TOK_MAX, 20'd0, 1'b0);
    drain();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_reg(tbca_pkg::CFG_POLICY, TOKEN_BITS'(plan[s].pol));
      write_reg(tbca_pkg::CFG_CHUNK_UNIT, plan[s].unit);
      write_reg(tbca_pkg::CFG_LIMIT_ON, TOKEN_BITS'(plan[s].lim));
      write_reg(tbca_pkg::CFG_MAX_LEN, plan[s].max_len);
      gaps_on <= plan[s].gaps;
      // token counts sized around the unit so trimming and alignment both show up
      scale = plan[s].unit * 4;
      if (scale < 256) scale = 256;
      if (scale > 32'(TOK_MAX)) scale = 32'(TOK_MAX);
      n = 0;
      while (n < REQS_PER_SETTING) begin
        if ($urandom_range(0, 99) < 85) begin
          // well-formed batch: a start word carrying the budget, then follow-ups
          batch_len = $urandom_range(1, 6);
          for (int i = 0; i < batch_len; i++) begin
            add_req(i == 0, $urandom_range(0, 3) != 0, pick_tokens(scale * 2),
                    pick_tokens(scale), pick_tokens(scale), 1'($urandom_range(0, 1)));
          end
          n += batch_len;
        end else begin
          // stray word: random start flag, full-width fields
          add_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  TOKEN_BITS'($urandom()), TOKEN_BITS'($urandom()),
                  TOKEN_BITS'($urandom()), 1'($urandom_range(0, 1)));
          n++;
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_grants.size() != 0) begin
      n_fail += expected_grants.size();
      $display("%0t: %0d grant words never arrived", $time, expected_grants.size());
    end

    $display("covered %0d requests over %0d register settings, greedy and forced chunks",
             n_accepted, NUM_SETTINGS + 3);
    $display("grants checked %0d: %0d config errors, %0d zero chunks",
             n_grants, n_cfg_err, n_starved);
    if (n_fail == 0) begin
      $display("[token_budget_chunk_assigner] OK");
    end else begin
      $display("[token_budget_chunk_assigner] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tbca_pkg.sv
hw/rtl/tbca_if.sv
hw/rtl/tbca_rem_div.sv
hw/rtl/token_budget_chunk_assigner.sv
test/token_budget_chunk_assigner_test.sv
